FILE: hdl/b32e_pkg.sv
// ---------------------------------------------------------------------------
// b32e_pkg: shared types and tables for the base32 stream encoder
// Holds the queue entry type, the alphabet lookup and default sizes.
// ---------------------------------------------------------------------------
package b32e_pkg;

    localparam int SYM_W         = 5;
    localparam int CHAR_W        = 7;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_W       = 3;
    localparam int DEF_Q_DEPTH   = 4;

    // One classified byte: up to three symbols and how many of them are used.
    typedef struct packed {
        logic [SYM_W-1:0] sym0;
        logic [SYM_W-1:0] sym1;
        logic [SYM_W-1:0] sym2;
        logic [1:0]       n_syms;
        logic             eom;
    } b32e_entry_t;

    // Maps a 5-bit symbol to the ASCII code of its alphabet character.
    function automatic logic [CHAR_W-1:0] b32e_char(input logic [SYM_W-1:0] sym);
        logic [CHAR_W-1:0] c;
        unique case (sym)
            5'd0:  c = 7'h30;
            5'd1:  c = 7'h31;
            5'd2:  c = 7'h32;
            5'd3:  c = 7'h33;
            5'd4:  c = 7'h34;
            5'd5:  c = 7'h35;
            5'd6:  c = 7'h36;
            5'd7:  c = 7'h37;
            5'd8:  c = 7'h38;
            5'd9:  c = 7'h39;
            5'd10: c = 7'h41;
            5'd11: c = 7'h42;
            5'd12: c = 7'h43;
            5'd13: c = 7'h44;
            5'd14: c = 7'h46;
            5'd15: c = 7'h47;
            5'd16: c = 7'h48;
            5'd17: c = 7'h4A;
            5'd18: c = 7'h4B;
            5'd19: c = 7'h4C;
            5'd20: c = 7'h4D;
            5'd21: c = 7'h4E;
            5'd22: c = 7'h50;
            5'd23: c = 7'h51;
            5'd24: c = 7'h52;
            5'd25: c = 7'h53;
            5'd26: c = 7'h54;
            5'd27: c = 7'h56;
            5'd28: c = 7'h57;
            5'd29: c = 7'h58;
            5'd30: c = 7'h59;
            default: c = 7'h5A;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/b32e_front.sv
// ---------------------------------------------------------------------------
// b32e_front: byte intake and symbol split
// Tracks the five-byte group position and slices each byte into symbols.
// ---------------------------------------------------------------------------
module b32e_front
    import b32e_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        data_byte,
    input  logic              end_of_message,
    input  logic              q_full,
    output logic              q_push,
    output b32e_entry_t       q_entry
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         prev_byte_reg, prev_byte_next;

    assign q_push = push && !q_full;

    always_comb
    begin
        q_entry.sym0   = '0;
        q_entry.sym1   = '0;
        q_entry.sym2   = '0;
        q_entry.n_syms = 2'd1;
        q_entry.eom    = end_of_message;
        unique case (phase_reg)
            3'd1:
            begin
                q_entry.sym0   = {prev_byte_reg[2:0], data_byte[7:6]};
                q_entry.sym1   = data_byte[5:1];
                q_entry.sym2   = {data_byte[0], 4'b0000};
                q_entry.n_syms = end_of_message ? 2'd3 : 2'd2;
            end
            3'd2:
            begin
                q_entry.sym0   = {prev_byte_reg[0], data_byte[7:4]};
                q_entry.sym1   = {data_byte[3:0], 1'b0};
                q_entry.n_syms = end_of_message ? 2'd2 : 2'd1;
            end
            3'd3:
            begin
                q_entry.sym0   = {prev_byte_reg[3:0], data_byte[7]};
                q_entry.sym1   = data_byte[6:2];
                q_entry.sym2   = {data_byte[1:0], 3'b000};
                q_entry.n_syms = end_of_message ? 2'd3 : 2'd2;
            end
            3'd4:
            begin
                // No bits are left over here, so the final byte adds no flush.
                q_entry.sym0   = {prev_byte_reg[1:0], data_byte[7:5]};
                q_entry.sym1   = data_byte[4:0];
                q_entry.n_syms = 2'd2;
            end
            default:
            begin
                // Phase zero; unused codes fall in here as well.
                q_entry.sym0   = data_byte[7:3];
                q_entry.sym1   = {data_byte[2:0], 2'b00};
                q_entry.n_syms = end_of_message ? 2'd2 : 2'd1;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        prev_byte_next = prev_byte_reg;
        if (q_push)
        begin
            if (end_of_message)
            begin
                phase_next     = '0;
                prev_byte_next = '0;
            end
            else
            begin
                // Unused codes act as phase zero, so they move on to phase one.
                if (phase_reg == PHASE_W'(NUM_PHASES - 1))
                    phase_next = '0;
                else if (phase_reg >= PHASE_W'(NUM_PHASES))
                    phase_next = PHASE_W'(1);
                else
                    phase_next = phase_reg + 1'b1;
                prev_byte_next = data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            prev_byte_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prev_byte_reg <= prev_byte_next;
        end
    end

endmodule

FILE: hdl/b32e_queue.sv
// ---------------------------------------------------------------------------
// b32e_queue: small entry queue between intake and output
// Register-based circular buffer with a fill count.
// ---------------------------------------------------------------------------
module b32e_queue
    import b32e_pkg::*;
#(
    parameter int DEPTH = DEF_Q_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  b32e_entry_t              wr_data,
    input  logic                     rd_en,
    output b32e_entry_t              rd_data,
    output logic                     full,
    output logic                     has_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b32e_entry_t      storage_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign has_data = (count_reg != '0);
    assign count    = count_reg;
    assign rd_data  = storage_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && has_data;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            storage_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hdl/b32e_back.sv
// ---------------------------------------------------------------------------
// b32e_back: character emitter
// Walks the symbols of the head entry and drives the output register.
// ---------------------------------------------------------------------------
module b32e_back
    import b32e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_has_data,
    input  b32e_entry_t        q_entry,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [CHAR_W-1:0]  out_char,
    output logic               last_char
);

    logic [1:0]        sym_idx_reg, sym_idx_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              load;
    logic              final_sym;
    logic [SYM_W-1:0]  cur_sym;

    assign empty     = !valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    // The output register takes a new word when it is free or being drained.
    assign load      = q_has_data && (!valid_reg || pop);
    assign final_sym = (sym_idx_reg == q_entry.n_syms - 2'd1);
    assign q_pop     = load && final_sym;

    always_comb
    begin
        unique case (sym_idx_reg)
            2'd0:    cur_sym = q_entry.sym0;
            2'd1:    cur_sym = q_entry.sym1;
            default: cur_sym = q_entry.sym2;
        endcase
    end

    always_comb
    begin
        sym_idx_next = sym_idx_reg;
        valid_next   = valid_reg;
        if (load)
        begin
            valid_next   = 1'b1;
            sym_idx_next = final_sym ? 2'd0 : sym_idx_reg + 2'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_idx_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            sym_idx_reg <= sym_idx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= b32e_char(cur_sym);
            last_reg <= q_entry.eom && final_sym;
        end
    end

endmodule

FILE: hdl/base32_stream_encoder_core.sv
// ---------------------------------------------------------------------------
// base32_stream_encoder_core: unpadded base32 encoder for a byte stream
// Intake, entry queue and character emitter joined at the top level.
// ---------------------------------------------------------------------------
// Usage:
// The input side is a queue write port. A byte word is taken on a rising
// edge with push high and full low; end_of_message marks the final byte.
// The output side is a queue read port. While empty is low, out_char holds
// the ASCII code of the oldest character and last_char flags the final
// character of a message; the word is taken on an edge with pop high.
// A byte yields one to three characters, and the output register emits one
// character per cycle while pop is high, so sustained throughput is set by that
// single port: about 1.6 characters per byte over a long message, up to three
// for a final byte. An accepted byte is first written to the entry queue and
// then loaded into the output register once that register is free or drained.
// A stalled receiver holds the current word; bytes keep being taken until
// the entry queue of QUEUE_DEPTH words fills, then full rises.
// Reset clears the group position, the previous byte, the queue and the
// output register; no clearing sweep is needed.
// ---------------------------------------------------------------------------
module base32_stream_encoder_core
    import b32e_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_Q_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_message,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] out_char,
    output logic              last_char
);

    b32e_entry_t                     wr_entry;
    b32e_entry_t                     head_entry;
    logic                            q_push;
    logic                            q_pop;
    logic                            q_full;
    logic                            q_has_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    assign full = q_full;

    // The front slices each byte by group position and queues the symbols.
    b32e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (wr_entry)
    );

    // The queue decouples intake from a stalled receiver.
    b32e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (wr_entry),
        .rd_en    (q_pop),
        .rd_data  (head_entry),
        .full     (q_full),
        .has_data (q_has_data),
        .count    (q_count)
    );

    // The back turns symbols into characters, one word per cycle while the receiver pops.
    b32e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_has_data (q_has_data),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .last_char  (last_char)
    );

`ifndef SYNTHESIS
    // Any shown character is within the alphabet's code range.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_char >= 7'd48 && out_char <= 7'd90))
        else $error("out_char outside the alphabet range");

    // An accepted byte leaves a character pending once its entry has passed the queue.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> ##1 !empty)
        else $error("accepted byte produced no pending character");

    // The queue fill count never exceeds its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // The queue is never popped while the back holds no head entry.
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_has_data)
        else $error("queue popped while empty");
`endif

endmodule

FILE: tb/base32_stream_encoder_core_test.sv
// ---------------------------------------------------------------------------
// base32_stream_encoder_core_test: self-checking bench for the base32 encoder
// Streams messages of random length and content through the byte queue side,
// predicts every character in a small class, and checks each popped word.
// ---------------------------------------------------------------------------
module base32_stream_encoder_core_test;
    import b32e_pkg::*;

    // The 32 alphabet characters packed left to right, one ASCII byte each.
    localparam logic [8*32-1:0] B32_ALPHABET = "0123456789ABCDFGHJKLMNPQRSTVWXYZ";

    // Number of bytes in the random part, and the point after which both
    // sides stop idling so the tail of the run goes at full rate.
    localparam int RANDOM_BYTES = 380;
    localparam int CALM_AFTER   = 300;

    // Position of the encoder inside its five-byte, eight-character group.
    typedef enum logic [PHASE_W-1:0] {
        GRP_0 = 3'd0,
        GRP_1 = 3'd1,
        GRP_2 = 3'd2,
        GRP_3 = 3'd3,
        GRP_4 = 3'd4
    } grp_phase_e;

    // One predicted output word.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } b32_char_t;

    // Character predictor: it tracks the group phase and the previous byte
    // exactly as the encoder should, and keeps the characters still owed.
    class b32_char_model;
        grp_phase_e phase;
        logic [7:0] prev_byte;
        b32_char_t  want_chars[$];

        function new();
            phase     = GRP_0;
            prev_byte = 8'h00;
        endfunction

        function void owe_symbol(logic [SYM_W-1:0] sym, logic last);
            b32_char_t c;
            c.code = B32_ALPHABET[8*(31-sym) +: CHAR_W];
            c.last = last;
            want_chars.push_back(c);
        endfunction

        // Called for every byte word the encoder accepts.
        function void take_byte(logic [7:0] b, logic eom);
            case (phase)
                GRP_0:
                begin
                    owe_symbol(b[7:3], 1'b0);
                    if (eom)
                        owe_symbol({b[2:0], 2'b00}, 1'b1);
                end
                GRP_1:
                begin
                    owe_symbol({prev_byte[2:0], b[7:6]}, 1'b0);
                    owe_symbol(b[5:1], 1'b0);
                    if (eom)
                        owe_symbol({b[0], 4'b0000}, 1'b1);
                end
                GRP_2:
                begin
                    owe_symbol({prev_byte[0], b[7:4]}, 1'b0);
                    if (eom)
                        owe_symbol({b[3:0], 1'b0}, 1'b1);
                end
                GRP_3:
                begin
                    owe_symbol({prev_byte[3:0], b[7]}, 1'b0);
                    owe_symbol(b[6:2], 1'b0);
                    if (eom)
                        owe_symbol({b[1:0], 3'b000}, 1'b1);
                end
                default:
                begin
                    // The fifth byte closes the group, so no flush is needed.
                    owe_symbol({prev_byte[1:0], b[7:5]}, 1'b0);
                    owe_symbol(b[4:0], eom);
                end
            endcase
            if (eom)
            begin
                phase     = GRP_0;
                prev_byte = 8'h00;
            end
            else
            begin
                phase     = (phase == GRP_4) ? GRP_0 : grp_phase_e'(phase + 1);
                prev_byte = b;
            end
        endfunction

        // Returns an empty string when the word matches the oldest owed one.
        function string match_char(logic [CHAR_W-1:0] code, logic last);
            b32_char_t want;
            string     msg;
            msg = "";
            if (want_chars.size() == 0)
                return $sformatf("character 0x%02h last=%0b with none owed", code, last);
            want = want_chars.pop_front();
            if (code !== want.code)
                msg = $sformatf("out_char 0x%02h, owed 0x%02h; ", code, want.code);
            if (last !== want.last)
                msg = {msg, $sformatf("last_char %0b, owed %0b", last, want.last)};
            return msg;
        endfunction

        function int owed();
            return want_chars.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [7:0]        data_byte;
    logic              end_of_message;
    logic              empty;
    logic              pop;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;

    b32_char_model char_model = new();
    int            mismatches = 0;
    int            bytes_sent = 0;
    bit            send_idle  = 1'b1;
    bit            recv_idle  = 1'b1;

    base32_stream_encoder_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run, even with every byte
    // flushing and both sides stalling.
    initial
    begin
        #1_000_000;
        $display("base32_stream_encoder_core test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Both handshakes are judged on values sampled right after the edge,
    // before any nonblocking update of that edge lands. The input side is
    // handled first so a word is always owed before it can be popped.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            string msg;
            if (push && !full)
                char_model.take_byte(data_byte, end_of_message);
            if (pop && !empty)
            begin
                msg = char_model.match_char(out_char, last_char);
                if (msg.len() != 0)
                    report_mismatch(msg);
            end
        end
    end

    // Receiver: pops every cycle, except for random stalls while recv_idle
    // is set. Exactly one assignment to pop per edge.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Offers one byte word and returns at the edge that takes it. A random
    // idle gap may come first while send_idle is set.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // A whole message of random bytes; only its final byte carries the mark.
    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial
    begin
        logic [7:0] corner_bytes [8];
        int         k;
        corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F, 8'hFE};

        push           = 1'b0;
        pop            = 1'b0;
        data_byte      = 8'h00;
        end_of_message = 1'b0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: messages of one to six bytes, so the final byte
        // lands once in every group phase (including the phase where no
        // flush character is due) and once again after the group wraps.
        // The bytes walk through all-zero, all-one and alternating patterns.
        k = 0;
        for (int len = 1; len <= 6; len++)
        begin
            for (int i = 0; i < len; i++)
            begin
                send_byte(corner_bytes[k % 8], i == len - 1);
                k++;
            end
        end

        // Random part: mostly short messages, now and then a long one that
        // runs through many groups. Idling on each side is switched per
        // message so there are stretches with and without gaps, and it is
        // off for the closing stretch.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent < CALM_AFTER)
            begin
                send_idle = ($urandom_range(0, 2) != 0);
                recv_idle = ($urandom_range(0, 2) != 0);
            end
            else
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                send_random_message($urandom_range(13, 40));
            else
                send_random_message($urandom_range(1, 12));
        end
        push <= 1'b0;

        // One more edge lets the checker note the final byte before the
        // owed count is read.
        @(posedge clk);

        // Drain: every owed character must come out, then a few quiet
        // cycles catch any word the encoder should not have produced.
        while (char_model.owed() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("base32_stream_encoder_core test passed");
        else
            $display("base32_stream_encoder_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/b32e_pkg.sv
hdl/b32e_front.sv
hdl/b32e_queue.sv
hdl/b32e_back.sv
hdl/base32_stream_encoder_core.sv
tb/base32_stream_encoder_core_test.sv
